// File: design/sound_level_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sound level frame parser
// Clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SOUND_LEVEL_FRAME_PARSER_MACROS_SVH
`define SOUND_LEVEL_FRAME_PARSER_MACROS_SVH

// Check a property on every clock edge outside reset
`define SLFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define SLFP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/slfp_pkg.sv
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared types and constants of the sound level frame parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;

    // Reset values of the sync header bytes
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hE1;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hDB;

    // Normalization: clamp(level + 6000, 0, 1000)
    localparam logic signed [16:0] NORM_OFFSET = 17'sd6000;
    localparam logic signed [16:0] NORM_MAX    = 17'sd1000;

    // Parser phases, one-hot
    typedef enum logic [5:0] {
        PH_WAIT_FIRST  = 6'b000001,
        PH_WAIT_SECOND = 6'b000010,
        PH_SEQ_LOW     = 6'b000100,
        PH_SEQ_HIGH    = 6'b001000,
        PH_LEVEL_LOW   = 6'b010000,
        PH_LEVEL_HIGH  = 6'b100000
    } phase_t;

endpackage

// File: design/slfp_norm.sv
// ----------------------------------------------------------------------------
// slfp_norm
// Maps a level in hundredths of dBFS onto 0..1000 thousandths with a clamp.
// ----------------------------------------------------------------------------
module slfp_norm
    import slfp_pkg::*;
(
    input  logic signed [15:0] level,
    output logic        [9:0]  norm
);

    logic signed [16:0] sum_s;

    // Offset the sign-extended level
    assign sum_s = $signed({level[15], level}) + NORM_OFFSET;

    // Clamp to the normalized range
    always_comb begin
        priority if (sum_s < 17'sd0) begin
            norm = 10'd0;
        end else if (sum_s > NORM_MAX) begin
            norm = NORM_MAX[9:0];
        end else begin
            norm = sum_s[9:0];
        end
    end

endmodule

// File: design/sound_level_frame_parser.sv
// ----------------------------------------------------------------------------
// sound_level_frame_parser
// Hunts for a two-byte sync header in a serial byte stream, skips the
// sequence number and emits the little-endian level with its normalized value.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; s_ready drops only when the last level byte
//   of a frame arrives while the previous result beat is still not taken.
// Output: the result beat is valid in the cycle after the last level byte.
// Reset (aresetn low at a clock edge): return to hunting for the first sync
//   byte, drop any pending result, restore the sync bytes to 0xE1 and 0xDB.
`include "sound_level_frame_parser_macros.svh"

module sound_level_frame_parser
    import slfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    // byte input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_level_hundredths,
    output logic [9:0]         m_norm_thousandths
);

    logic [7:0]         sync_first_reg;
    logic [7:0]         sync_second_reg;
    phase_t             phase_reg, phase_next;
    logic [7:0]         level_low_reg, level_low_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_level_reg;
    logic [9:0]         out_norm_reg;
    logic               in_beat;
    logic               emit;
    logic signed [15:0] level_now;
    logic [9:0]         norm_now;

    // Stall only when a new result would overwrite an untaken one
    assign s_ready = !(phase_reg == PH_LEVEL_HIGH && out_valid_reg && !m_ready);
    assign in_beat = s_valid && s_ready;
    assign emit    = in_beat && (phase_reg == PH_LEVEL_HIGH);

    // Assemble the level from the stored low byte and the incoming high byte
    assign level_now = $signed({s_rx_byte, level_low_reg});

    slfp_norm u_norm (
        .level (level_now),
        .norm  (norm_now)
    );

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_we) begin
            if (cfg_index == CFG_SYNC_FIRST) begin
                sync_first_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_SYNC_SECOND) begin
                sync_second_reg <= cfg_wdata;
            end
        end
    end

    // Advance the parser on each accepted byte
    always_comb begin
        phase_next     = phase_reg;
        level_low_next = level_low_reg;
        if (in_beat) begin
            unique case (phase_reg)
                PH_WAIT_SECOND: begin
                    priority if (s_rx_byte == sync_second_reg) begin
                        phase_next = PH_SEQ_LOW;
                    end else if (s_rx_byte == sync_first_reg) begin
                        phase_next = PH_WAIT_SECOND;
                    end else begin
                        phase_next = PH_WAIT_FIRST;
                    end
                end
                PH_SEQ_LOW: begin
                    phase_next = PH_SEQ_HIGH;
                end
                PH_SEQ_HIGH: begin
                    phase_next = PH_LEVEL_LOW;
                end
                PH_LEVEL_LOW: begin
                    level_low_next = s_rx_byte;
                    phase_next     = PH_LEVEL_HIGH;
                end
                PH_LEVEL_HIGH: begin
                    phase_next = PH_WAIT_FIRST;
                end
                default: begin
                    phase_next = (s_rx_byte == sync_first_reg) ? PH_WAIT_SECOND
                                                                : PH_WAIT_FIRST;
                end
            endcase
        end
    end

    // Hold the result beat until taken, load a new one on frame end
    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT_FIRST;
            level_low_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            level_low_reg <= level_low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_level_reg <= level_now;
            out_norm_reg  <= norm_now;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_level_hundredths = out_level_reg;
    assign m_norm_thousandths = out_norm_reg;

    // A new result beat appears only after the last level byte was taken
    `SLFP_ASSERT(a_rise_after_frame, $rose(m_valid) |-> $past(emit), "result without frame end")
    // Stall only at the last level byte with a pending result
    `SLFP_ASSERT_IMPL(a_stall_cause, !s_ready, phase_reg == PH_LEVEL_HIGH && m_valid && !m_ready, "unexpected input stall")
    // Normalized level stays in range
    `SLFP_ASSERT_IMPL(a_norm_range, m_valid, m_norm_thousandths <= 10'd1000, "normalized level out of range")
    // After a frame end the parser is back to hunting
    `SLFP_ASSERT(a_frame_restart, emit |=> phase_reg == PH_WAIT_FIRST, "parser did not restart")

endmodule
